### rtl/rbsi_pkg.sv
// Shared constants for the ray versus box slab test.
package rbsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_Z = 3'd5;

endpackage

### rtl/ray_box_slab_intersection.sv
// Top level of the ray versus axis-aligned box slab test.
//
// One ray transfer is taken in every clock cycle: a ray is accepted at each
// rising edge where start is high and busy is low, and busy is only high
// while rst is asserted. Each result comes out as a one-cycle done strobe
// with hit valid in that same cycle (default format Q16.16); the receiver
// cannot stall it, so it must take every strobe. The pipeline is the
// reciprocal divider, which produces one quotient bit per pipeline stage,
// plus an input register, three stages of plane difference, multiply and
// scaling, and two stages that merge the three slabs. The box corners are
// written through cfg_write, cfg_index and cfg_data; they should only change
// while no ray is in flight, since the pipeline reads them late. Indices
// above the six box registers are ignored.
module ray_box_slab_intersection #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     cfg_write,
  input  logic [rbsi_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]                   cfg_data,
  input  logic signed [COORD_WIDTH-1:0]            origin_x,
  input  logic signed [COORD_WIDTH-1:0]            origin_y,
  input  logic signed [COORD_WIDTH-1:0]            origin_z,
  input  logic signed [COORD_WIDTH-1:0]            heading_x,
  input  logic signed [COORD_WIDTH-1:0]            heading_y,
  input  logic signed [COORD_WIDTH-1:0]            heading_z,
  input  logic signed [COORD_WIDTH-1:0]            near_limit,
  input  logic signed [COORD_WIDTH-1:0]            far_limit,
  output logic                                     done,
  output logic                                     hit
);
  import rbsi_pkg::*;

  localparam int W        = COORD_WIDTH;
  localparam int AXIS_LAT = 2 * FRAC_BITS + 1 + 3;
  localparam int LATENCY  = AXIS_LAT + 3;

  assign busy = rst;

  // Box registers.
  logic signed [W-1:0] box_lo [0:2];
  logic signed [W-1:0] box_hi [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= W'(64'd1 << FRAC_BITS);
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_lo[0] <= cfg_data;
        REG_BOX_MIN_Y: box_lo[1] <= cfg_data;
        REG_BOX_MIN_Z: box_lo[2] <= cfg_data;
        REG_BOX_MAX_X: box_hi[0] <= cfg_data;
        REG_BOX_MAX_Y: box_hi[1] <= cfg_data;
        REG_BOX_MAX_Z: box_hi[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic                accept;
  logic                in_valid;
  logic signed [W-1:0] pos_r [0:2];
  logic signed [W-1:0] dir_r [0:2];
  logic signed [W-1:0] t0_r;
  logic signed [W-1:0] t1_r;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    pos_r[0] <= origin_x;
    pos_r[1] <= origin_y;
    pos_r[2] <= origin_z;
    dir_r[0] <= heading_x;
    dir_r[1] <= heading_y;
    dir_r[2] <= heading_z;
    t0_r     <= near_limit;
    t1_r     <= far_limit;
  end

  // The three slabs run side by side.
  logic signed [W-1:0] en [0:2];
  logic signed [W-1:0] ex [0:2];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_axis #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_axis (
      .clk       (clk),
      .pos       (pos_r[a]),
      .dir       (dir_r[a]),
      .box_lo    (box_lo[a]),
      .box_hi    (box_hi[a]),
      .entry     (en[a]),
      .exit_dist (ex[a])
    );
  end

  // Valid bits and interval limits follow the slab pipeline.
  logic                vld_d [0:AXIS_LAT];
  logic signed [W-1:0] t0_d  [0:AXIS_LAT];
  logic signed [W-1:0] t1_d  [0:AXIS_LAT];

  assign vld_d[0] = in_valid;
  assign t0_d[0]  = t0_r;
  assign t1_d[0]  = t1_r;

  for (genvar k = 0; k < AXIS_LAT; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_d[k+1] <= 1'b0;
      end else begin
        vld_d[k+1] <= vld_d[k];
      end
      t0_d[k+1] <= t0_d[k];
      t1_d[k+1] <= t1_d[k];
    end
  end

  // First merge: x and y slabs, early reject when they cannot meet.
  logic                m1_valid;
  logic                m1_reject;
  logic signed [W-1:0] m1_tmin;
  logic signed [W-1:0] m1_tmax;
  logic signed [W-1:0] m1_en2;
  logic signed [W-1:0] m1_ex2;
  logic signed [W-1:0] m1_t0;
  logic signed [W-1:0] m1_t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= vld_d[AXIS_LAT];
    end
    m1_reject <= (en[0] > ex[1]) || (en[1] > ex[0]);
    m1_tmin   <= (en[1] > en[0]) ? en[1] : en[0];
    m1_tmax   <= (ex[1] < ex[0]) ? ex[1] : ex[0];
    m1_en2    <= en[2];
    m1_ex2    <= ex[2];
    m1_t0     <= t0_d[AXIS_LAT];
    m1_t1     <= t1_d[AXIS_LAT];
  end

  // Second merge: z slab, then the open interval overlap.
  logic                reject2;
  logic signed [W-1:0] tmin2;
  logic signed [W-1:0] tmax2;
  logic                hit_next;

  always_comb begin
    reject2  = (m1_tmin > m1_ex2) || (m1_en2 > m1_tmax);
    tmin2    = (m1_en2 > m1_tmin) ? m1_en2 : m1_tmin;
    tmax2    = (m1_ex2 < m1_tmax) ? m1_ex2 : m1_tmax;
    hit_next = m1_valid && !m1_reject && !reject2 && (m1_t0 < tmax2) && (tmin2 < m1_t1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= m1_valid;
      hit  <= hit_next;
    end
  end

  // Every accepted ray later produces its strobe at the end of the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result strobe missing after fixed latency");

  // A strobe always traces back to an accepted ray.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(m1_valid))
    else $error("result strobe without a ray in flight");

  // hit is only ever raised together with its strobe.
  a_hit_qualified: assert property (@(posedge clk)
    hit |-> done)
    else $error("hit raised outside a result transfer");

  // Reset empties the pipeline.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !done && !m1_valid)
    else $error("pipeline not cleared by reset");

endmodule

### rtl/rbsi_recip.sv
// Pipelined restoring divider forming 2^(2*FRAC_BITS) / magnitude, one quotient bit per stage.
module rbsi_recip #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic [COORD_WIDTH-1:0] divisor,
  output logic [2*FRAC_BITS:0]   quotient
);
  import rbsi_pkg::*;

  localparam int NST = 2 * FRAC_BITS + 1;

  logic [COORD_WIDTH-1:0] rem [0:NST];
  logic [COORD_WIDTH-1:0] dvs [0:NST];
  logic [NST-1:0]         quo [0:NST];

  assign rem[0] = '0;
  assign dvs[0] = divisor;
  assign quo[0] = '0;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [COORD_WIDTH:0] shifted;
    logic [COORD_WIDTH:0] trial;
    logic                 fits;

    // Only the top dividend bit is set.
    assign shifted = {rem[k], (k == 0) ? 1'b1 : 1'b0};
    assign trial   = shifted - {1'b0, dvs[k]};
    assign fits    = shifted >= {1'b0, dvs[k]};

    always_ff @(posedge clk) begin
      rem[k+1] <= fits ? trial[COORD_WIDTH-1:0] : shifted[COORD_WIDTH-1:0];
      dvs[k+1] <= dvs[k];
      quo[k+1] <= {quo[k][NST-2:0], fits};
    end
  end

  assign quotient = quo[NST];

endmodule

### rtl/rbsi_axis.sv
// One axis of the slab test: reciprocal, plane differences, products and scaling.
module rbsi_axis #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH-1:0] pos,
  input  logic signed [COORD_WIDTH-1:0] dir,
  input  logic signed [COORD_WIDTH-1:0] box_lo,
  input  logic signed [COORD_WIDTH-1:0] box_hi,
  output logic signed [COORD_WIDTH-1:0] entry,
  output logic signed [COORD_WIDTH-1:0] exit_dist
);
  import rbsi_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int QW  = 2 * FRAC_BITS + 1;
  localparam int NST = QW;
  localparam int CW  = ((QW > W) ? QW : W) + 1;
  localparam logic [CW-1:0] MAX_MAG = CW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [CW-1:0] MIN_MAG = CW'(64'd1 << (W - 1));
  localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]         dir_mag;
  logic [QW-1:0]        quotient;
  logic signed [W-1:0]  pos_d  [0:NST];
  logic                 neg_d  [0:NST];
  logic                 zero_d [0:NST];

  assign dir_mag = dir[W-1] ? W'(-dir) : W'(dir);

  rbsi_recip #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_recip (
    .clk      (clk),
    .divisor  (dir_mag),
    .quotient (quotient)
  );

  assign pos_d[0]  = pos;
  assign neg_d[0]  = dir[W-1];
  assign zero_d[0] = (dir == '0);

  for (genvar k = 0; k < NST; k++) begin : g_delay
    always_ff @(posedge clk) begin
      pos_d[k+1]  <= pos_d[k];
      neg_d[k+1]  <= neg_d[k];
      zero_d[k+1] <= zero_d[k];
    end
  end

  // Saturate the reciprocal and pick the near and far planes.
  logic [CW-1:0]        q_ext;
  logic [W-1:0]         inv_mag_c;
  logic                 inv_neg_c;
  logic signed [W-1:0]  near_pl;
  logic signed [W-1:0]  far_pl;
  logic signed [W:0]    near_diff;
  logic signed [W:0]    far_diff;
  logic signed [W-1:0]  near_sat;
  logic signed [W-1:0]  far_sat;

  always_comb begin
    q_ext = CW'(quotient);
    if (zero_d[NST]) begin
      inv_mag_c = W'(MAX_MAG);
      inv_neg_c = 1'b0;
    end else if (neg_d[NST]) begin
      inv_mag_c = (q_ext >= MIN_MAG) ? W'(MIN_MAG) : W'(q_ext);
      inv_neg_c = (q_ext != '0);
    end else begin
      inv_mag_c = (q_ext > MAX_MAG) ? W'(MAX_MAG) : W'(q_ext);
      inv_neg_c = 1'b0;
    end
    near_pl   = inv_neg_c ? box_hi : box_lo;
    far_pl    = inv_neg_c ? box_lo : box_hi;
    near_diff = {near_pl[W-1], near_pl} - {pos_d[NST][W-1], pos_d[NST]};
    far_diff  = {far_pl[W-1], far_pl} - {pos_d[NST][W-1], pos_d[NST]};
    if (near_diff[W] != near_diff[W-1]) begin
      near_sat = near_diff[W] ? MIN_VAL : MAX_VAL;
    end else begin
      near_sat = near_diff[W-1:0];
    end
    if (far_diff[W] != far_diff[W-1]) begin
      far_sat = far_diff[W] ? MIN_VAL : MAX_VAL;
    end else begin
      far_sat = far_diff[W-1:0];
    end
  end

  logic [W-1:0] inv_mag;
  logic         inv_neg;
  logic [W-1:0] near_mag;
  logic         near_neg;
  logic [W-1:0] far_mag;
  logic         far_neg;

  always_ff @(posedge clk) begin
    inv_mag  <= inv_mag_c;
    inv_neg  <= inv_neg_c;
    near_mag <= near_sat[W-1] ? W'(-near_sat) : W'(near_sat);
    near_neg <= near_sat[W-1];
    far_mag  <= far_sat[W-1] ? W'(-far_sat) : W'(far_sat);
    far_neg  <= far_sat[W-1];
  end

  logic [2*W-1:0] near_prod;
  logic [2*W-1:0] far_prod;
  logic           near_prod_neg;
  logic           far_prod_neg;

  always_ff @(posedge clk) begin
    near_prod     <= (2*W)'(near_mag) * (2*W)'(inv_mag);
    far_prod      <= (2*W)'(far_mag) * (2*W)'(inv_mag);
    near_prod_neg <= near_neg ^ inv_neg;
    far_prod_neg  <= far_neg ^ inv_neg;
  end

  // Drop the fraction bits and saturate to the coordinate range.
  localparam logic [2*W-1:0] PMAX = (2*W)'(MAX_MAG);
  localparam logic [2*W-1:0] PMIN = (2*W)'(MIN_MAG);

  logic [2*W-1:0]      near_sh;
  logic [2*W-1:0]      far_sh;
  logic signed [W-1:0] entry_c;
  logic signed [W-1:0] exit_c;

  always_comb begin
    near_sh = near_prod >> FRAC_BITS;
    far_sh  = far_prod >> FRAC_BITS;
    if (near_prod_neg) begin
      entry_c = (near_sh >= PMIN) ? MIN_VAL : W'(-near_sh);
    end else begin
      entry_c = (near_sh > PMAX) ? MAX_VAL : W'(near_sh);
    end
    if (far_prod_neg) begin
      exit_c = (far_sh >= PMIN) ? MIN_VAL : W'(-far_sh);
    end else begin
      exit_c = (far_sh > PMAX) ? MAX_VAL : W'(far_sh);
    end
  end

  always_ff @(posedge clk) begin
    entry     <= entry_c;
    exit_dist <= exit_c;
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for the ray versus axis-aligned box slab test.
module testbench;
  import rbsi_pkg::*;

  localparam int W = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int PIPE_LATENCY = 2 * FB + 7;
  localparam int STALL_LIMIT = 5000;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_HI = 3'd7;
  localparam longint ONE = 64'sd1 <<< FB;

  typedef struct {
    logic signed [W-1:0] org[3];
    logic signed [W-1:0] dir[3];
    logic signed [W-1:0] t_near;
    logic signed [W-1:0] t_far;
  } ray_t;

  // The scoreboard keeps its own copy of the box corners and predicts the hit
  // flag of every accepted ray transfer; results come back strictly in order.
  class hit_scoreboard;
    longint box_lo[3];
    longint box_hi[3];
    bit pending_hits[$];
    int mismatches;
    int checked;
    int hits_seen;

    function void reset_box();
      for (int a = 0; a < 3; a++) begin
        box_lo[a] = 0;
        box_hi[a] = ONE;
      end
    endfunction

    function void write_box(logic [CFG_INDEX_WIDTH-1:0] idx, logic [W-1:0] value);
      longint v;
      v = longint'($signed(value));
      if (idx < 3) box_lo[idx] = v;
      else if (idx < 6) box_hi[idx - 3] = v;
    endfunction

    function longint clamp(longint v);
      longint top;
      top = (64'sd1 <<< (W - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
    endfunction

    // Reciprocal of a Q format value; zero counts as positive and saturates.
    function longint inverse(longint d);
      longint unsigned m;
      longint unsigned q;
      m = (d < 0) ? longint'(-d) : longint'(d);
      if (m == 0) return clamp(64'sh7fff_ffff_ffff_ffff);
      q = (64'd1 << (2 * FB)) / m;
      return clamp((d < 0) ? -longint'(q) : longint'(q));
    endfunction

    // Fixed point product, magnitude truncated toward zero, then saturated.
    function longint scaled_product(longint a, longint b);
      longint unsigned x;
      longint unsigned y;
      longint unsigned p;
      x = (a < 0) ? longint'(-a) : longint'(a);
      y = (b < 0) ? longint'(-b) : longint'(b);
      p = (x * y) >> FB;
      return clamp(((a < 0) != (b < 0)) ? -longint'(p) : longint'(p));
    endfunction

    function bit slab_hit(ray_t r);
      longint tmin, tmax, inv, near_pl, far_pl, en, ex, pos;
      tmin = 0;
      tmax = 0;
      for (int a = 0; a < 3; a++) begin
        pos = longint'(r.org[a]);
        inv = inverse(longint'(r.dir[a]));
        near_pl = (inv < 0) ? box_hi[a] : box_lo[a];
        far_pl = (inv < 0) ? box_lo[a] : box_hi[a];
        en = scaled_product(clamp(near_pl - pos), inv);
        ex = scaled_product(clamp(far_pl - pos), inv);
        if (a == 0) begin
          tmin = en;
          tmax = ex;
        end else begin
          // Slabs that cannot overlap reject the ray at once.
          if (tmin > ex || en > tmax) return 1'b0;
          if (en > tmin) tmin = en;
          if (ex < tmax) tmax = ex;
        end
      end
      return (longint'(r.t_near) < tmax) && (tmin < longint'(r.t_far));
    endfunction

    function void note_ray(ray_t r);
      pending_hits = {pending_hits, slab_hit(r)};
    endfunction

    function void check_hit(logic actual);
      bit want;
      if (pending_hits.size() == 0) begin
        $error("hit: result with no ray in flight, actual %b", actual);
        mismatches++;
        return;
      end
      want = pending_hits.pop_front();
      checked++;
      if (actual === 1'b1) hits_seen++;
      if (actual !== want) begin
        $error("hit: expected %b, actual %b", want, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [W-1:0] cfg_data;
  logic signed [W-1:0] origin_x, origin_y, origin_z;
  logic signed [W-1:0] heading_x, heading_y, heading_z;
  logic signed [W-1:0] near_limit, far_limit;
  logic done;
  logic hit;

  hit_scoreboard sb;
  int idle_pct;
  int rays_sent;
  int quiet_cycles;

  ray_box_slab_intersection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .heading_x(heading_x), .heading_y(heading_y), .heading_z(heading_z),
    .near_limit(near_limit), .far_limit(far_limit),
    .done(done), .hit(hit)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Both monitors sample at the rising edge, before the driver's nonblocking
  // updates land, so a transfer is seen exactly as the block sees it.
  always @(posedge clk) begin
    ray_t r;
    if (!rst && start && !busy) begin
      r.org[0] = origin_x;
      r.org[1] = origin_y;
      r.org[2] = origin_z;
      r.dir[0] = heading_x;
      r.dir[1] = heading_y;
      r.dir[2] = heading_z;
      r.t_near = near_limit;
      r.t_far = far_limit;
      sb.note_ray(r);
    end
    if (!rst && done) sb.check_hit(hit);
  end

  // The watchdog restarts on every accepted transfer in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One register write, after which the write port goes quiet again.
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_box(idx, value);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_box(longint lx, longint ly, longint lz,
                          longint hx, longint hy, longint hz);
    write_reg(REG_BOX_MIN_X, lx[W-1:0]);
    write_reg(REG_BOX_MIN_Y, ly[W-1:0]);
    write_reg(REG_BOX_MIN_Z, lz[W-1:0]);
    write_reg(REG_BOX_MAX_X, hx[W-1:0]);
    write_reg(REG_BOX_MAX_Y, hy[W-1:0]);
    write_reg(REG_BOX_MAX_Z, hz[W-1:0]);
  endtask

  // Holds a ray on the ports until the block takes it, then idles at random.
  task automatic send_ray(ray_t r);
    start <= 1'b1;
    origin_x <= r.org[0];
    origin_y <= r.org[1];
    origin_z <= r.org[2];
    heading_x <= r.dir[0];
    heading_y <= r.dir[1];
    heading_z <= r.dir[2];
    near_limit <= r.t_near;
    far_limit <= r.t_far;
    do @(posedge clk); while (busy !== 1'b0);
    rays_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Waits for every result in flight, then lets the pipeline empty out.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  function automatic ray_t make_ray(ray_t base, longint ox, longint oy, longint oz,
                                    longint dx, longint dy, longint dz,
                                    longint tn, longint tf);
    ray_t r;
    r = base;
    r.org[0] = ox[W-1:0];
    r.org[1] = oy[W-1:0];
    r.org[2] = oz[W-1:0];
    r.dir[0] = dx[W-1:0];
    r.dir[1] = dy[W-1:0];
    r.dir[2] = dz[W-1:0];
    r.t_near = tn[W-1:0];
    r.t_far = tf[W-1:0];
    return r;
  endfunction

  // Mostly rays aimed near a box a few units wide, with full-range noise mixed in.
  function automatic ray_t random_ray();
    ray_t r;
    longint tn;
    if ($urandom_range(99) < 20) begin
      for (int a = 0; a < 3; a++) begin
        r.org[a] = $urandom;
        r.dir[a] = ($urandom_range(9) == 0) ? '0 : W'($urandom);
      end
      r.t_near = $urandom;
      r.t_far = $urandom;
    end else begin
      for (int a = 0; a < 3; a++) begin
        r.org[a] = W'(longint'($urandom_range(16 * 65536)) - 8 * ONE);
        case ($urandom_range(9))
          0: r.dir[a] = '0;
          1: r.dir[a] = W'(longint'($urandom_range(64)) - 32);
          default: r.dir[a] = W'(longint'($urandom_range(4 * 65536)) - 2 * ONE);
        endcase
      end
      tn = longint'($urandom_range(8 * 65536)) - 4 * ONE;
      r.t_near = W'(tn);
      r.t_far = ($urandom_range(9) == 0) ? W'(tn - longint'($urandom_range(65536)))
                                         : W'(tn + longint'($urandom_range(16 * 65536)));
    end
    return r;
  endfunction

  task automatic directed_rays();
    ray_t z;
    longint mx, mn;
    mx = (64'sd1 <<< (W - 1)) - 1;
    mn = -mx - 1;
    z = '{default: '0};
    // Straight through the unit box along each axis, some of them from behind.
    send_ray(make_ray(z, -ONE, ONE/2, ONE/2, ONE, 0, 0, 0, 10 * ONE));
    send_ray(make_ray(z, 2 * ONE, ONE/2, ONE/2, -ONE, 0, 0, 0, 10 * ONE));
    send_ray(make_ray(z, ONE/2, -ONE, ONE/2, 0, 2 * ONE, 0, 0, 10 * ONE));
    send_ray(make_ray(z, ONE/2, ONE/2, 3 * ONE, 0, 0, -ONE/4, 0, 100 * ONE));
    // Misses, pointed away and offset sideways, and a zero direction from inside the box.
    send_ray(make_ray(z, -ONE, ONE/2, ONE/2, -ONE, 0, 0, 0, 10 * ONE));
    send_ray(make_ray(z, -ONE, 3 * ONE, ONE/2, ONE, 0, 0, 0, 10 * ONE));
    send_ray(make_ray(z, ONE/2, ONE/2, ONE/2, 0, 0, 0, mn, mx));
    // Empty and reversed intervals, and an interval that stops just short of the box.
    send_ray(make_ray(z, -ONE, ONE/2, ONE/2, ONE, 0, 0, 5 * ONE, 5 * ONE));
    send_ray(make_ray(z, -ONE, ONE/2, ONE/2, ONE, 0, 0, 3 * ONE, ONE));
    send_ray(make_ray(z, -ONE, ONE/2, ONE/2, ONE, 0, 0, 0, ONE));
    // Tiny and extreme directions exercise reciprocal and product saturation.
    send_ray(make_ray(z, -ONE, ONE/2, ONE/2, 1, -1, 1, mn, mx));
    send_ray(make_ray(z, mn, mx, mn, mx, mn, mx, mn, mx));
    send_ray(make_ray(z, mx, mn, mx, mn, mx, mn, mn, mx));
    send_ray(make_ray(z, mx, mx, mx, -1, -1, -1, mx, mn));
    send_ray(make_ray(z, mn, mn, mn, 1, 1, 1, -1, 0));
    send_ray(make_ray(z, 0, 0, 0, mn, 0, mx, mn, mx));
    send_ray(make_ray(z, ONE, ONE, ONE, ONE, ONE, ONE, -ONE, ONE));
    send_ray(make_ray(z, 0, 0, 0, -ONE, -ONE, -ONE, mn, 0));
  endtask

  task automatic random_rays(int count);
    for (int i = 0; i < count; i++) send_ray(random_ray());
  endtask

  initial begin
    sb = new();
    sb.reset_box();
    rst = 1'b1;
    start = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {origin_x, origin_y, origin_z} = '0;
    {heading_x, heading_y, heading_z} = '0;
    {near_limit, far_limit} = '0;
    idle_pct = 0;
    rays_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset box with directed rays, back to back and then with idling.
    directed_rays();
    idle_pct = 78;
    random_rays(250);
    drain();

    // A random box a few units wide; writes to unused indices must be ignored.
    load_box(-longint'($urandom_range(4 * 65536)), -longint'($urandom_range(4 * 65536)),
             -longint'($urandom_range(4 * 65536)), longint'($urandom_range(4 * 65536)),
             longint'($urandom_range(4 * 65536)), longint'($urandom_range(4 * 65536)));
    write_reg(REG_UNUSED_LO, $urandom);
    write_reg(REG_UNUSED_HI, $urandom);
    idle_pct = 0;
    directed_rays();
    random_rays(350);
    idle_pct = 37;
    random_rays(250);
    drain();

    // The widest box the registers hold.
    load_box(-(64'sd1 <<< (W - 1)), -(64'sd1 <<< (W - 1)), -(64'sd1 <<< (W - 1)),
             (64'sd1 <<< (W - 1)) - 1, (64'sd1 <<< (W - 1)) - 1, (64'sd1 <<< (W - 1)) - 1);
    idle_pct = 78;
    directed_rays();
    random_rays(150);
    drain();

    // A crossed box, min above max on every axis, and a lopsided one.
    load_box(ONE, 2 * ONE, ONE, -ONE, 0, -2 * ONE);
    idle_pct = 37;
    random_rays(150);
    drain();
    load_box(-3 * ONE, 0, ONE/2, -ONE, 5 * ONE, ONE/2 + 1);
    idle_pct = 0;
    random_rays(150);
    drain();

    $display("Sent %0d rays over five box settings; %0d results checked, %0d hits.",
             rays_sent, sb.checked, sb.hits_seen);
    if (sb.mismatches == 0 && sb.pending_hits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/rbsi_pkg.sv
rtl/rbsi_recip.sv
rtl/rbsi_axis.sv
rtl/ray_box_slab_intersection.sv
tb/testbench.sv
